>>> hdl/star_point_projector_macros.svh
`ifndef STAR_POINT_PROJECTOR_MACROS_SVH
`define STAR_POINT_PROJECTOR_MACROS_SVH

// same-cycle implication
`define SPP_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SPP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/spp_pkg.sv
package spp_pkg;

   localparam int QuotBits  = 28;
   localparam int RemBits   = 17;
   localparam int FadeBits  = 8;
   localparam int CellCount = QuotBits;

   localparam logic [16:0] DepthNear = 17'd2048;
   localparam logic [23:0] DepthFar  = 24'd76800;
   localparam logic [16:0] FadeSpan  = 17'd74752;
   localparam logic [31:0] RectOpcode = 32'hF600_0000;
   localparam logic [7:0]  AlphaFull  = 8'hFF;

   localparam logic [1:0] RegScale  = 2'd0;
   localparam logic [1:0] RegWidth  = 2'd1;
   localparam logic [1:0] RegHeight = 2'd2;

   typedef struct packed {
      logic signed [23:0] star_x;
      logic signed [23:0] star_y;
      logic signed [23:0] star_z;
      logic               final_star;
   } req_type;

   typedef struct packed {
      logic        visible;
      logic [31:0] color_word;
      logic [31:0] rect_first_word;
      logic [31:0] rect_second_word;
      logic        final_out;
   } rsp_type;

   typedef struct packed {
      logic                valid;
      logic                fin;
      logic                in_range;
      logic                neg_x;
      logic                neg_y;
      logic [RemBits-1:0]  divisor;
      logic [RemBits-1:0]  rem_x;
      logic [RemBits-1:0]  rem_y;
      logic [RemBits-1:0]  rem_f;
      logic [QuotBits-1:0] bits_x;
      logic [QuotBits-1:0] bits_y;
      logic [FadeBits-1:0] bits_f;
   } stage_type;

endpackage

>>> hdl/spp_front.sv
module spp_front import spp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        accept,
   input  req_type     req_data,
   input  logic [23:0] scale,
   output stage_type   stage_out
);

   logic               a_valid_ff;
   logic               a_fin_ff;
   logic               a_range_ff;
   logic [16:0]        a_z_ff;
   logic signed [47:0] a_px_ff;
   logic signed [47:0] a_py_ff;
   logic [24:0]        a_f_ff;
   logic signed [48:0] px_full;
   logic signed [48:0] py_full;
   logic [16:0]        fz;
   logic               range_in;
   logic [47:0]        mag_x;
   logic [47:0]        mag_y;
   stage_type          stage_in;
   stage_type          stage_ff;

   always_comb begin
      px_full  = req_data.star_x * $signed({1'b0, scale});
      py_full  = req_data.star_y * $signed({1'b0, scale});
      fz       = req_data.star_z[16:0] - DepthNear;
      range_in = (req_data.star_z >= $signed({7'd0, DepthNear})) &&
                 (req_data.star_z < $signed(DepthFar));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= accept;
      end
      a_fin_ff   <= req_data.final_star;
      a_range_ff <= range_in;
      a_z_ff     <= req_data.star_z[16:0];
      a_px_ff    <= px_full[47:0];
      a_py_ff    <= py_full[47:0];
      a_f_ff     <= fz * 8'd255;
   end

   always_comb begin
      mag_x = a_px_ff[47] ? 48'(-a_px_ff) : a_px_ff;
      mag_y = a_py_ff[47] ? 48'(-a_py_ff) : a_py_ff;
      stage_in.valid    = a_valid_ff;
      stage_in.fin      = a_fin_ff;
      stage_in.in_range = a_range_ff;
      stage_in.neg_x    = a_px_ff[47];
      stage_in.neg_y    = a_py_ff[47];
      stage_in.divisor  = a_z_ff;
      stage_in.rem_x    = {6'd0, mag_x[46:36]};
      stage_in.rem_y    = {6'd0, mag_y[46:36]};
      stage_in.bits_x   = mag_x[35:8];
      stage_in.bits_y   = mag_y[35:8];
      stage_in.rem_f    = a_f_ff[24:8];
      stage_in.bits_f   = a_f_ff[7:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else begin
         stage_ff <= stage_in;
      end
   end

   assign stage_out = stage_ff;

endmodule

>>> hdl/spp_cell.sv
module spp_cell import spp_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      fade_en,
   input  stage_type stage_prev,
   output stage_type stage_out
);

   logic [RemBits:0] try_x;
   logic [RemBits:0] try_y;
   logic [RemBits:0] try_f;
   logic             ge_x;
   logic             ge_y;
   logic             ge_f;
   stage_type        stage_in;
   stage_type        stage_ff;

   always_comb begin
      try_x = {stage_prev.rem_x, stage_prev.bits_x[QuotBits-1]};
      try_y = {stage_prev.rem_y, stage_prev.bits_y[QuotBits-1]};
      try_f = {stage_prev.rem_f, stage_prev.bits_f[FadeBits-1]};
      ge_x  = try_x >= {1'b0, stage_prev.divisor};
      ge_y  = try_y >= {1'b0, stage_prev.divisor};
      ge_f  = try_f >= {1'b0, FadeSpan};
      stage_in        = stage_prev;
      stage_in.rem_x  = ge_x ? RemBits'(try_x - {1'b0, stage_prev.divisor})
                             : try_x[RemBits-1:0];
      stage_in.rem_y  = ge_y ? RemBits'(try_y - {1'b0, stage_prev.divisor})
                             : try_y[RemBits-1:0];
      stage_in.bits_x = {stage_prev.bits_x[QuotBits-2:0], ge_x};
      stage_in.bits_y = {stage_prev.bits_y[QuotBits-2:0], ge_y};
      if (fade_en) begin
         stage_in.rem_f  = ge_f ? RemBits'(try_f - {1'b0, FadeSpan})
                                : try_f[RemBits-1:0];
         stage_in.bits_f = {stage_prev.bits_f[FadeBits-2:0], ge_f};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else begin
         stage_ff <= stage_in;
      end
   end

   assign stage_out = stage_ff;

endmodule

>>> hdl/spp_back.sv
module spp_back import spp_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  stage_type stage_last,
   input  logic [9:0] screen_w,
   input  logic [9:0] screen_h,
   output logic      rsp_valid,
   output rsp_type   rsp_data
);

   logic signed [30:0] px;
   logic signed [30:0] py;
   logic signed [30:0] sx;
   logic signed [30:0] sy;
   logic               vis;
   logic [7:0]         shade;
   logic [31:0]        ux;
   logic [31:0]        uy;
   logic               rsp_valid_ff;
   rsp_type            rsp_in;
   rsp_type            rsp_ff;

   always_comb begin
      px = stage_last.neg_x ? -$signed({3'd0, stage_last.bits_x})
                            :  $signed({3'd0, stage_last.bits_x});
      py = stage_last.neg_y ? -$signed({3'd0, stage_last.bits_y})
                            :  $signed({3'd0, stage_last.bits_y});
      sx = px + $signed({22'd0, screen_w[9:1]});
      sy = $signed({22'd0, screen_h[9:1]}) - py;
      vis = stage_last.in_range && !sx[30] && !sy[30] &&
            (sx < $signed({21'd0, screen_w})) && (sy < $signed({21'd0, screen_h}));
      shade = 8'd255 - stage_last.bits_f;
      ux = {22'd0, sx[9:0]};
      uy = {22'd0, sy[9:0]};
      rsp_in.visible          = vis;
      rsp_in.final_out        = stage_last.fin;
      rsp_in.color_word       = vis ? {shade, shade, shade, AlphaFull} : 32'd0;
      rsp_in.rect_first_word  = vis ? (RectOpcode | ((ux + 32'd1) << 14) | ((uy + 32'd1) << 2))
                                    : 32'd0;
      rsp_in.rect_second_word = vis ? ((ux << 14) | (uy << 2)) : 32'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= stage_last.valid;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> hdl/star_point_projector.sv
// Star point projector.
// A request (one star, Q16.8 x/y/z plus a last-star flag) is taken on any
// clock where start is high; busy is always low, so a new star may enter
// every cycle and throughput is one star per clock.
// Each request yields exactly one response, rsp_valid high for one cycle
// with rsp_data, after the multiply and magnitude registers, 28 divider
// cells (one quotient bit each, the depth fade divider riding in the
// first 8), and the centering, clipping and command formatting register.
// Responses come out in request order.
// The receiver has no stall; it must take every response as it appears.
// Registers sit on the APB port at byte addresses 0 (projection scale),
// 4 (screen width) and 8 (screen height); write them only when no star
// is in flight. Synchronous reset empties the pipeline and restores
// scale 256.0, width 320 and height 240.
`include "star_point_projector_macros.svh"

module star_point_projector import spp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_data,
   output logic        rsp_valid,
   output rsp_type     rsp_data,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic [23:0] scale_ff;
   logic [9:0]  width_ff;
   logic [9:0]  height_ff;
   logic        wr_en;
   stage_type   chain [CellCount+1];

   assign busy   = 1'b0;
   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff  <= 24'd65536;
         width_ff  <= 10'd320;
         height_ff <= 10'd240;
      end else if (wr_en) begin
         case (paddr[3:2])
            RegScale:  scale_ff  <= pwdata[23:0];
            RegWidth:  width_ff  <= pwdata[9:0];
            RegHeight: height_ff <= pwdata[9:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         RegScale:  prdata = {8'd0, scale_ff};
         RegWidth:  prdata = {22'd0, width_ff};
         RegHeight: prdata = {22'd0, height_ff};
         default:   prdata = 32'd0;
      endcase
   end

   spp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (start && !busy),
      .req_data  (req_data),
      .scale     (scale_ff),
      .stage_out (chain[0])
   );

   for (genvar i = 0; i < CellCount; i++) begin : g_cell
      spp_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .fade_en    (i < FadeBits),
         .stage_prev (chain[i]),
         .stage_out  (chain[i+1])
      );
   end

   spp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .stage_last (chain[CellCount]),
      .screen_w   (width_ff),
      .screen_h   (height_ff),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data)
   );

   `SPP_ASSERT_NOW(a_invisible_zero, clock, reset, rsp_valid && !rsp_data.visible, (rsp_data.color_word == 32'd0) && (rsp_data.rect_first_word == 32'd0) && (rsp_data.rect_second_word == 32'd0), "invisible star carries nonzero words")
   `SPP_ASSERT_NOW(a_visible_alpha, clock, reset, rsp_valid && rsp_data.visible, (rsp_data.color_word[7:0] == AlphaFull) && (rsp_data.color_word[31:24] != 8'd0), "visible star color malformed")
   `SPP_ASSERT_NEXT(a_chain_to_rsp, clock, reset, chain[CellCount].valid, rsp_valid, "last cell did not produce a response")

endmodule
